### rtl/hbp_pkg.sv
// ----------------------------------------------------------------------------
// hbp_pkg
// Shared widths, function codes and types of the Huffman bit packer.
// ----------------------------------------------------------------------------
package hbp_pkg;

    localparam int FUNC_W  = 2;
    localparam int SYM_W   = 8;
    localparam int CODE_W  = 23;
    localparam int LEN_W   = 5;
    localparam int BYTE_W  = 8;
    localparam int TDATA_W = 40;   // symbol + code_bits + code_len, byte padded

    // pending bits (at most 7) plus one full code
    localparam int ACC_W   = 7 + CODE_W;
    localparam int CNT_W   = 5;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam int DEF_MAX_CODE_LEN = 23;
    localparam int DEF_ALPHABET     = 256;

    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ENCODE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd2;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;   // bits above len are zero
    } t_code;

    typedef struct packed {
        logic  fin;
        t_code c;
    } t_entry;

endpackage

### rtl/hbp_front.sv
// ----------------------------------------------------------------------------
// hbp_front
// Accepts input items, keeps the code table and looks up codes for encode
// and finish items; lookups leave through a registered stage to the queue.
// ----------------------------------------------------------------------------
module hbp_front
    import hbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
    parameter int ALPHABET     = DEF_ALPHABET
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [SYM_W-1:0]  i_symbol,
    input  logic [CODE_W-1:0] i_code_bits,
    input  logic [LEN_W-1:0]  i_code_len,
    output logic              o_push,
    input  logic              i_full,
    output t_entry            o_entry
);

    localparam int AW      = $clog2(ALPHABET);
    localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    t_code              r_table [ALPHABET];
    t_code              r_rd;
    logic               r_fin;
    logic               r_vld;
    logic               n_vld;

    logic               accept;
    logic               sym_ok;
    logic               do_load;
    logic               do_look;
    logic               is_fin;
    logic [AW-1:0]      addr;
    logic [LEN_W-1:0]   len_sat;
    t_code              wr_val;

    assign accept = i_valid && o_ready;
    assign sym_ok = {1'b0, i_symbol} < (SYM_W + 1)'(ALPHABET);
    assign addr   = is_fin ? AW'(0) : i_symbol[AW-1:0];

    always_comb begin
        do_load = 1'b0;
        do_look = 1'b0;
        is_fin  = 1'b0;
        case (i_func)
            FUNC_LOAD:   do_load = sym_ok;
            FUNC_ENCODE: do_look = sym_ok;
            FUNC_FINISH: begin
                do_look = 1'b1;
                is_fin  = 1'b1;
            end
            default: ;
        endcase
    end

    assign len_sat = (i_code_len > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : i_code_len;

    always_comb begin
        wr_val.len  = len_sat;
        wr_val.code = i_code_bits & ~({CODE_W{1'b1}} << len_sat);
    end

    always_ff @(posedge i_clk) begin
        if (accept && do_load) begin
            r_table[addr] <= wr_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && do_look) begin
            r_rd  <= r_table[addr];
            r_fin <= is_fin;
        end
    end

    // stage drains into the queue whenever there is room
    assign o_push  = r_vld && !i_full;
    assign o_ready = !r_vld || !i_full;

    always_comb begin
        n_vld = r_vld;
        if (accept && do_look) begin
            n_vld = 1'b1;
        end else if (o_push) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_comb begin
        o_entry.fin = r_fin;
        o_entry.c   = r_rd;
    end

endmodule

### rtl/hbp_fifo.sv
// ----------------------------------------------------------------------------
// hbp_fifo
// Short queue of looked-up codes between the front and the packer.
// ----------------------------------------------------------------------------
module hbp_fifo
    import hbp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_data,
    output logic   o_full,
    output logic   o_valid,
    input  logic   i_pop,
    output t_entry o_data
);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wp;
    logic [QPTR_W-1:0]   r_rp;
    logic [QCNT_W-1:0]   r_cnt;
    logic [QCNT_W-1:0]   n_cnt;

    assign o_full  = r_cnt == QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + QCNT_W'(1);
            2'b01:   n_cnt = r_cnt - QCNT_W'(1);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + QPTR_W'(1);
            if (i_pop)  r_rp <= r_rp + QPTR_W'(1);
            r_cnt <= n_cnt;
        end
    end

endmodule

### rtl/hbp_back.sv
// ----------------------------------------------------------------------------
// hbp_back
// Bit accumulator: appends codes MSB first and emits one byte per cycle while the output is ready,
// pads and flags the final byte of a finish.
// ----------------------------------------------------------------------------
module hbp_back
    import hbp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_entry            i_q_data,
    output logic              o_q_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_byte,
    output logic              o_last
);

    logic [ACC_W-1:0]  r_acc;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_fin;
    logic              r_ovalid;
    logic [BYTE_W-1:0] r_obyte;
    logic              r_olast;

    logic [ACC_W-1:0]  n_acc;
    logic [CNT_W-1:0]  n_cnt;
    logic              n_fin;

    logic              out_free;
    logic              has_byte;
    logic              emit_full;
    logic              pad;
    logic              pop;
    logic [CNT_W-1:0]  rem;
    logic [ACC_W-1:0]  kept;
    logic [ACC_W-1:0]  shifted;
    logic [BYTE_W-1:0] byte_full;
    logic [BYTE_W-1:0] byte_pad;

    assign out_free  = !r_ovalid || i_ready;
    assign has_byte  = r_cnt >= CNT_W'(8);
    assign emit_full = has_byte && out_free;
    assign rem       = has_byte ? r_cnt - CNT_W'(8) : r_cnt;
    assign pad       = r_fin && !has_byte && out_free;

    // append the next code in the same cycle the byte before it leaves
    assign pop = i_q_valid && !r_fin && (!has_byte || emit_full) && (rem < CNT_W'(8));
    assign o_q_pop = pop;

    assign kept      = r_acc & ~({ACC_W{1'b1}} << rem);
    assign shifted   = r_acc >> (r_cnt - CNT_W'(8));
    assign byte_full = shifted[BYTE_W-1:0];
    assign byte_pad  = r_acc[BYTE_W-1:0] << (CNT_W'(8) - r_cnt);

    always_comb begin
        n_acc = r_acc;
        n_cnt = r_cnt;
        n_fin = r_fin;
        if (pop) begin
            n_acc = (kept << i_q_data.c.len) | ACC_W'(i_q_data.c.code);
            n_cnt = rem + i_q_data.c.len;
            n_fin = i_q_data.fin;
        end else if (emit_full) begin
            n_cnt = rem;
        end else if (pad) begin
            n_cnt = '0;
            n_fin = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_fin    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_fin <= n_fin;
            if (emit_full || (pad && r_cnt != '0)) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (emit_full) begin
            r_obyte <= byte_full;
            // a finish that ends on a byte boundary flags its last full byte
            r_olast <= r_fin && (r_cnt == CNT_W'(8));
        end else if (pad) begin
            r_obyte <= byte_pad;
            r_olast <= 1'b1;
        end
    end

    assign o_valid = r_ovalid;
    assign o_byte  = r_obyte;
    assign o_last  = r_olast;

endmodule

### rtl/huffman_bit_packer.sv
// ----------------------------------------------------------------------------
// huffman_bit_packer
// Huffman encoder back end: code table, lookup front, queue and byte packer.
// ----------------------------------------------------------------------------
// channel   dir   tdata                               tuser   tlast
// s_axis    in    symbol, code_bits, code_len         func    -
// m_axis    out   out_byte                            -       last
//
// A load writes the code table. An encode or finish is looked up and
// registered, and then yields one output byte per cycle in the packer
// while m_axis is ready; the packer appends the next code while its last
// byte leaves. After its full bytes a finish takes a pad step, which sends
// any partial byte, and the next code is appended only after that step.
// Synchronous active-low reset clears control; the code table is not cleared.
// A four-entry queue lets input and output stall independently.
// ----------------------------------------------------------------------------
module huffman_bit_packer
    import hbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
    parameter int ALPHABET     = DEF_ALPHABET
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,   // symbol[7:0], code_bits[30:8], code_len[35:31]
    input  logic [FUNC_W-1:0]  s_axis_tuser,   // func[1:0]
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [BYTE_W-1:0]  m_axis_tdata,   // out_byte[7:0]
    output logic               m_axis_tlast
);

    logic   push;
    logic   q_full;
    logic   q_valid;
    logic   q_pop;
    t_entry push_data;
    t_entry q_data;

    hbp_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .ALPHABET     (ALPHABET)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_func      (s_axis_tuser),
        .i_symbol    (s_axis_tdata[SYM_W-1:0]),
        .i_code_bits (s_axis_tdata[SYM_W+CODE_W-1:SYM_W]),
        .i_code_len  (s_axis_tdata[SYM_W+CODE_W+LEN_W-1:SYM_W+CODE_W]),
        .o_push      (push),
        .i_full      (q_full),
        .o_entry     (push_data)
    );

    hbp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_data)
    );

    hbp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_byte    (m_axis_tdata),
        .o_last    (m_axis_tlast)
    );

endmodule
